// File: hw/rtl/ltp_pkg.sv
// Shared types and constants for the Legendre triple product block.
package ltp_pkg;
    localparam int DEG_W      = 8;
    localparam int ACC_W      = 48;
    localparam int ACC_FRAC   = 40;
    localparam int OUT_W      = 34;
    localparam int OUT_SHIFT  = 8;
    localparam int MAX_DEGREE = 255;
    localparam int CNT_W      = 11;  // holds 2s+1 for degrees up to 682

    // Control from sequencer to the multiply-divide unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] mul;
        logic [CNT_W-1:0] div;
    } ltp_md_req_t;
endpackage

// File: hw/rtl/ltp_muldiv.sv
// Shared unit: acc = floor(acc * mul / div), bit-serial restoring divide.
module ltp_muldiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ltp_pkg::ltp_md_req_t        req,
    input  logic [ltp_pkg::ACC_W-1:0]   acc_in,
    output logic [ltp_pkg::ACC_W-1:0]   acc_out,
    output logic                        done
);
    import ltp_pkg::*;

    localparam int PW = ACC_W + CNT_W;
    localparam int BW = $clog2(PW + 1);

    logic [PW-1:0]    num_reg, num_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    // One quotient bit per cycle; quotient shifts into num_reg.
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CNT_W-1:0], num_reg[PW-1]};
        if (req.start)
        begin
            num_next  = PW'(acc_in) * PW'(req.mul);
            div_next  = req.div;
            rem_next  = '0;
            bit_next  = BW'(PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                num_next = {num_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[PW-2:0], 1'b0};
            end
            bit_next = bit_reg - 1'b1;
            if (bit_reg == BW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign acc_out = num_reg[ACC_W-1:0];
    assign done    = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start) else $error("start while busy");
    a_bits_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> bit_reg == '0) else $error("bit count off");
endmodule

// File: hw/rtl/legendre_triple_product.sv
// Legendre triple product: one integral of P_l*P_m*P_n over [-1,1] per input beat,
// computed by a single shared multiply-divide unit. Each ratio step issues the
// product, runs the serial divider through its quotient bits, waits for done and
// moves to the next index; an item takes 2s+1 steps where s=(l+m+n)/2, plus a pass
// through the issue state at each of the four phase changes, then rounding and
// output. Items that fail the selection rule skip the steps and go from load
// straight to rounding. The block takes no new beat while an item is in work;
// the result sits in an output register.
module legendre_triple_product #(
    parameter int MAX_DEGREE = ltp_pkg::MAX_DEGREE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ltp_pkg::DEG_W-1:0]   second_degree,
    input  logic [ltp_pkg::DEG_W-1:0]   third_degree,
    input  logic                        last_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ltp_pkg::OUT_W-1:0]   integral_value,
    output logic                        rule_met,
    output logic                        last_out
);
    import ltp_pkg::*;

    localparam logic [1:0] REG_FIRST_DEGREE = 2'd0;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_ISSUE = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    // phase 0: up-run over 2s, 1..3: down-runs, 4: final divide
    localparam logic [2:0] PH_UP = 3'd0, PH_DN_N = 3'd1, PH_DN_M = 3'd2,
                           PH_DN_L = 3'd3, PH_FIN = 3'd4;

    state_t           state_reg, state_next;
    logic [DEG_W-1:0] l_reg;
    logic [DEG_W-1:0] m_reg, n_reg;
    logic             last_reg;
    logic             ok_reg;
    logic [2:0]       ph_reg, ph_next;
    logic [CNT_W-1:0] i_reg, i_next;       // current odd i
    logic [CNT_W-1:0] lim;                 // run length 2k
    logic [CNT_W-1:0] s_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] md_out;
    logic             md_done;
    ltp_md_req_t      md_req;
    logic [OUT_W-1:0] val_reg;
    logic             ov_reg;
    logic             ok_c;
    logic [CNT_W-1:0] sum_c;
    logic [ACC_W-OUT_SHIFT:0] rnd;

    // Config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIRST_DEGREE) ? {24'd0, l_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_FIRST_DEGREE)
            l_reg <= pwdata[DEG_W-1:0];
    end

    // Selection rule
    assign sum_c = CNT_W'(l_reg) + CNT_W'(second_degree) + CNT_W'(third_degree);
    assign ok_c = !sum_c[0]
        && (CNT_W'(second_degree) <= CNT_W'(l_reg) + CNT_W'(third_degree))
        && (CNT_W'(third_degree) <= CNT_W'(l_reg) + CNT_W'(second_degree))
        && (CNT_W'(l_reg) <= CNT_W'(second_degree) + CNT_W'(third_degree))
        && (int'(l_reg) <= MAX_DEGREE) && (int'(second_degree) <= MAX_DEGREE)
        && (int'(third_degree) <= MAX_DEGREE);

    // Run limit (2k) for the current phase
    always_comb
    begin
        case (ph_reg)
            PH_UP:   lim = s_reg << 1;
            PH_DN_N: lim = (s_reg - CNT_W'(n_reg)) << 1;
            PH_DN_M: lim = (s_reg - CNT_W'(m_reg)) << 1;
            PH_DN_L: lim = (s_reg - CNT_W'(l_reg)) << 1;
            default: lim = '0;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        i_next     = i_reg;
        md_req     = '0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_LOAD;
            S_LOAD:
            begin
                ph_next = PH_UP;
                i_next  = CNT_W'(1);
                state_next = ok_reg ? S_ISSUE : S_ROUND;
            end
            S_ISSUE:
            begin
                if (ph_reg == PH_FIN)
                begin
                    md_req.start = 1'b1;
                    md_req.mul   = CNT_W'(1);
                    md_req.div   = (s_reg << 1) + CNT_W'(1);
                    state_next   = S_WAIT;
                end
                else if (i_reg + CNT_W'(1) <= lim)
                begin
                    md_req.start = 1'b1;
                    md_req.mul   = (ph_reg == PH_UP) ? i_reg + CNT_W'(1) : i_reg;
                    md_req.div   = (ph_reg == PH_UP) ? i_reg : i_reg + CNT_W'(1);
                    state_next   = S_WAIT;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                    i_next  = CNT_W'(1);
                end
            end
            S_WAIT:
                if (md_done)
                    state_next = S_NEXT;
            S_NEXT:
            begin
                if (ph_reg == PH_FIN)
                    state_next = S_ROUND;
                else
                begin
                    i_next     = i_reg + CNT_W'(2);
                    state_next = S_ISSUE;
                end
            end
            S_ROUND:
                state_next = S_OUT;
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_UP;
            i_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            i_reg     <= i_next;
            ov_reg    <= (state_next == S_OUT);
        end
    end

    // Payload registers
    assign rnd = (ACC_W-OUT_SHIFT+1)'((acc_reg + ACC_W'(1 << (OUT_SHIFT-1))) >> OUT_SHIFT);
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            m_reg    <= second_degree;
            n_reg    <= third_degree;
            last_reg <= last_in;
            ok_reg   <= ok_c;
            s_reg    <= sum_c >> 1;
            acc_reg  <= ACC_W'(2) << ACC_FRAC;
        end
        else if (state_reg == S_WAIT && md_done)
            acc_reg <= md_out;
        if (state_reg == S_ROUND)
        begin
            if (!ok_reg)
                val_reg <= '0;
            else if (rnd > (ACC_W-OUT_SHIFT+1)'(1) << 33)
                val_reg <= OUT_W'(1) << 33;
            else
                val_reg <= OUT_W'(rnd);
        end
    end

    ltp_muldiv u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (md_req),
        .acc_in  (acc_reg),
        .acc_out (md_out),
        .done    (md_done)
    );

    assign out_valid      = ov_reg;
    assign integral_value = val_reg;
    assign rule_met       = ok_reg;
    assign last_out       = last_reg;

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == (state_reg == S_OUT)) else $error("out_valid mismatch");
    a_zero_when_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rule_met |-> integral_value == '0) else $error("nonzero on fail");
    a_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> integral_value <= (OUT_W'(1) << 33)) else $error("over cap");
endmodule
